// File: hdl/svm_pkg.sv
`default_nettype none

package svm_pkg;

    // Field and register widths
    localparam int CMD_W        = 2;
    localparam int VOICE_W      = 2;
    localparam int ADDR_FIELD_W = 14;
    localparam int SAMPLE_W     = 16;
    localparam int POS_W        = 15;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 15;
    localparam int S_TDATA_W    = 32;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 16;
    localparam int M_TUSER_W    = 1;

    // Voices that own a length register
    localparam int LENGTH_REGS = 4;

    // Defaults for the top-level parameters
    localparam int DEF_VOICES      = 4;
    localparam int DEF_VOICE_DEPTH = 16384;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [POS_W-1:0] IDLE_POSITION = 15'd16384;
    localparam int SAT_HIGH = 32767;
    localparam int SAT_LOW  = -32768;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_TRIGGER = 2'd1,
        CMD_TICK    = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_LEN0   = 3'd1,
        REG_LEN1   = 3'd2,
        REG_LEN2   = 3'd3,
        REG_LEN3   = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_TRIGGER = 2'd1,
        OP_TICK    = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic [VOICE_W-1:0]       voice;
        logic [ADDR_FIELD_W-1:0]  address;
        logic [SAMPLE_W-1:0]      sample;
    } op_t;

    typedef logic [LENGTH_REGS-1:0][POS_W-1:0] length_array_t;

endpackage

`default_nettype wire

// File: hdl/sample_voice_mixer_core.sv
// Four-voice sample playback mixer.
// Input words arrive on the s_ channel. s_tuser carries the command (load, trigger,
// tick); s_tdata carries the voice, the sample address and the sample value. A load
// writes one 16-bit sample into the addressed voice memory, a trigger restarts a voice
// at position zero while playback is enabled, and a tick mixes one output sample.
// Each tick yields exactly one word on the m_ channel: the saturated sum in m_tdata
// and the clip flag in m_tuser. Loads and triggers yield no output word.
// The cfg channel writes the enable flag (index 0) and the voice lengths (1 to 4);
// it is always ready; the user writes it only while the mixer is idle (not enforced).
// A tick passes from the command queue into the memory read stage and then into the
// output register before it appears on m_tvalid. Throughput is one word per cycle
// for every command while the receiver does not stall, set by the single read port
// of each voice memory and the one-word output register.
// When the receiver stalls, the finished word waits in the output register, one tick
// more waits in the read stage, and the two-entry command queue absorbs further
// words before s_tready drops. Reset puts every voice idle, enables playback and
// clears the lengths; sample memory is not cleared and needs no clearing pass.

`default_nettype none

module sample_voice_mixer_core #(
    parameter int VOICES      = svm_pkg::DEF_VOICES,
    parameter int VOICE_DEPTH = svm_pkg::DEF_VOICE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // s_tdata, from bit 0 up: voice[1:0], address[13:0], sample_word[15:0]
    input  wire logic [svm_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: cmd[1:0]
    input  wire logic [svm_pkg::S_TUSER_W-1:0]   s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // m_tdata: mixed_sample[15:0]
    output logic [svm_pkg::M_TDATA_W-1:0]        m_tdata,
    // m_tuser: clipped
    output logic [svm_pkg::M_TUSER_W-1:0]        m_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [svm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [svm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import svm_pkg::*;

    // Command path: front classifies and drops no-op words, queue decouples,
    // back owns the voice memories, positions and the mixing pipeline.
    logic          push;
    op_t           push_op;
    logic          push_ready;
    logic          pop_valid;
    op_t           pop_op;
    logic          pop;
    length_array_t lengths;

    svm_front #(
        .VOICES      (VOICES),
        .VOICE_DEPTH (VOICE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_op    (push_op),
        .push_ready (push_ready),
        .lengths    (lengths)
    );

    svm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_op     (pop_op),
        .pop        (pop)
    );

    svm_back #(
        .VOICES      (VOICES),
        .VOICE_DEPTH (VOICE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (pop_valid),
        .op       (pop_op),
        .op_pop   (pop),
        .lengths  (lengths),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// File: hdl/svm_front.sv
`default_nettype none

module svm_front #(
    parameter int VOICES      = svm_pkg::DEF_VOICES,
    parameter int VOICE_DEPTH = svm_pkg::DEF_VOICE_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [svm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [svm_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [svm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [svm_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                push,
    output svm_pkg::op_t                        push_op,
    input  wire logic                           push_ready,
    output svm_pkg::length_array_t              lengths
);
    import svm_pkg::*;

    logic                      enable_reg;
    length_array_t             length_reg;
    logic [VOICE_W-1:0]        voice;
    logic [ADDR_FIELD_W-1:0]   address;
    logic [SAMPLE_W-1:0]       sample;
    logic                      voice_ok;
    logic                      addr_ok;
    logic                      keep;
    op_kind_t                  kind;

    assign cfg_ready = 1'b1;
    assign lengths   = length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            length_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ENABLE: enable_reg    <= cfg_data[0];
                REG_LEN0:   length_reg[0] <= cfg_data;
                REG_LEN1:   length_reg[1] <= cfg_data;
                REG_LEN2:   length_reg[2] <= cfg_data;
                REG_LEN3:   length_reg[3] <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign voice   = s_tdata[VOICE_W-1:0];
    assign address = s_tdata[VOICE_W+ADDR_FIELD_W-1:VOICE_W];
    assign sample  = s_tdata[VOICE_W+ADDR_FIELD_W+SAMPLE_W-1:VOICE_W+ADDR_FIELD_W];

    assign voice_ok = 32'(voice) < VOICES;
    assign addr_ok  = 32'(address) < VOICE_DEPTH;

    // Words that change nothing are taken and dropped here.
    always_comb
    begin
        keep = 1'b0;
        kind = OP_TICK;
        unique case (s_tuser)
            CMD_LOAD:
            begin
                keep = voice_ok && addr_ok;
                kind = OP_LOAD;
            end
            CMD_TRIGGER:
            begin
                keep = voice_ok && enable_reg;
                kind = OP_TRIGGER;
            end
            CMD_TICK:
            begin
                keep = 1'b1;
                kind = OP_TICK;
            end
            default:
            begin
                keep = 1'b0;
                kind = OP_TICK;
            end
        endcase
    end

    assign s_tready        = push_ready;
    assign push            = s_tvalid && push_ready && keep;
    assign push_op.kind    = kind;
    assign push_op.voice   = voice;
    assign push_op.address = address;
    assign push_op.sample  = sample;

endmodule

`default_nettype wire

// File: hdl/svm_queue.sv
`default_nettype none

module svm_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire svm_pkg::op_t push_op,
    output logic              push_ready,
    output logic              pop_valid,
    output svm_pkg::op_t      pop_op,
    input  wire logic         pop
);
    import svm_pkg::*;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               do_pop;

    assign push_ready = count_reg != COUNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("command queue holds more entries than it has");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        !push_ready |-> !push)
        else $error("command pushed into a full queue");

endmodule

`default_nettype wire

// File: hdl/svm_back.sv
`default_nettype none

module svm_back #(
    parameter int VOICES      = svm_pkg::DEF_VOICES,
    parameter int VOICE_DEPTH = svm_pkg::DEF_VOICE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          op_valid,
    input  wire svm_pkg::op_t                  op,
    output logic                               op_pop,
    input  wire svm_pkg::length_array_t        lengths,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [svm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [svm_pkg::M_TUSER_W-1:0]      m_tuser
);
    import svm_pkg::*;

    localparam int ADDR_W = $clog2(VOICE_DEPTH);
    localparam int SUM_W  = SAMPLE_W + $clog2(VOICES) + 1;
    localparam logic [ADDR_W-1:0] IDLE_ADDR = ADDR_W'(IDLE_POSITION % VOICE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VOICE_DEPTH - 1);

    logic [POS_W-1:0]           pos_reg     [VOICES];
    logic [ADDR_W-1:0]          rd_addr_reg [VOICES];
    logic signed [SAMPLE_W-1:0] rd_data_reg [VOICES];
    logic [VOICES-1:0]          active_reg;
    logic                       s1_valid_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_sample_reg;
    logic                       out_clip_reg;

    logic [POS_W-1:0]           len_of  [VOICES];
    logic [VOICES-1:0]          active;
    logic [VOICES-1:0]          hit;
    logic [ADDR_W-1:0]          wr_addr;
    logic                       s1_advance;
    logic                       tick_issue;
    logic                       is_load;
    logic                       is_trigger;
    logic signed [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0]        sat_sample;
    logic                       sat_clip;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign is_load    = op_valid && (op.kind == OP_LOAD);
    assign is_trigger = op_valid && (op.kind == OP_TRIGGER);
    assign tick_issue = op_valid && (op.kind == OP_TICK) && (!s1_valid_reg || s1_advance);
    assign op_pop     = is_load || is_trigger || tick_issue;
    assign wr_addr    = ADDR_W'(op.address);

    for (genvar gv = 0; gv < VOICES; gv++)
    begin : g_voice
        logic [SAMPLE_W-1:0] mem [VOICE_DEPTH];

        if (gv < LENGTH_REGS)
        begin : g_len
            assign len_of[gv] = lengths[gv];
        end
        else
        begin : g_nolen
            assign len_of[gv] = '0;
        end

        assign active[gv] = pos_reg[gv] < len_of[gv];
        assign hit[gv]    = 32'(op.voice) == gv;

        always_ff @(posedge clk)
        begin
            if (is_load && hit[gv])
                mem[wr_addr] <= op.sample;
            if (tick_issue)
                rd_data_reg[gv] <= mem[rd_addr_reg[gv]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                pos_reg[v]     <= IDLE_POSITION;
                rd_addr_reg[v] <= IDLE_ADDR;
            end
        end
        else
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                if (is_trigger && hit[v])
                begin
                    pos_reg[v]     <= '0;
                    rd_addr_reg[v] <= '0;
                end
                else if (tick_issue && active[v])
                begin
                    pos_reg[v] <= pos_reg[v] + 1'b1;
                    if (pos_reg[v] == '1 || rd_addr_reg[v] == LAST_ADDR)
                        rd_addr_reg[v] <= '0;
                    else
                        rd_addr_reg[v] <= rd_addr_reg[v] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_issue)
            active_reg <= active;
    end

    always_comb
    begin
        sum = '0;
        for (int v = 0; v < VOICES; v++)
        begin
            if (active_reg[v])
                sum = sum + SUM_W'(rd_data_reg[v]);
        end
    end

    always_comb
    begin
        sat_sample = SAMPLE_W'(sum);
        sat_clip   = 1'b0;
        if (sum > SUM_W'(SAT_HIGH))
        begin
            sat_sample = SAMPLE_W'(SAT_HIGH);
            sat_clip   = 1'b1;
        end
        else if (sum < SUM_W'(SAT_LOW))
        begin
            sat_sample = SAMPLE_W'(SAT_LOW);
            sat_clip   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_issue)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;

            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_sample_reg <= sat_sample;
            out_clip_reg   <= sat_clip;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_clip_reg;

    a_read_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |-> !tick_issue)
        else $error("tick issued over a stalled read stage");

    a_tick_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
        tick_issue |=> s1_valid_reg)
        else $error("issued tick did not reach the read stage");

    a_clip_is_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_clip_reg) |->
            (out_sample_reg == SAMPLE_W'(SAT_HIGH) || out_sample_reg == SAMPLE_W'(SAT_LOW)))
        else $error("clip flag set on an unsaturated sample");

endmodule

`default_nettype wire

// File: tb/tb_sample_voice_mixer_core.sv
`default_nettype none

module tb_sample_voice_mixer_core;
    import svm_pkg::*;

    // cmd 3 has no meaning in the block; it must be swallowed without a result.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Cycles to let pass after the last mixed word before the block counts as idle.
    // A load or trigger makes no word, so it may still sit in the queue.
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_WORDS   = 110;
    localparam int PHASES        = 6;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    sample_voice_mixer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // 12-unit clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mixer prediction. The testbench keeps its own copy of the voice
    // memories, the play positions and the register file, and advances
    // them once for every word that the block accepts. Each tick pushes
    // the mixed word it should produce onto pending_mixes.
    // ------------------------------------------------------------------
    typedef struct {
        logic [SAMPLE_W-1:0] mixed;
        logic                clipped;
    } mix_word_t;

    mix_word_t           pending_mixes[$];
    logic [SAMPLE_W-1:0] voice_mem [0:DEF_VOICES*DEF_VOICE_DEPTH-1];
    // Tracks which sample words were ever loaded, so that no tick is ever
    // sent that would make the block mix an unwritten memory word.
    bit                  mem_loaded [0:DEF_VOICES*DEF_VOICE_DEPTH-1];
    logic [POS_W-1:0]    voice_pos [0:DEF_VOICES-1];
    logic [POS_W-1:0]    voice_len [0:LENGTH_REGS-1];
    logic                play_enabled;

    int        mismatch_count = 0;
    int        cycle_count    = 0;
    bit        tx_steady      = 1'b0;
    bit        rx_steady      = 1'b0;
    int        rx_hold        = 0;
    mix_word_t want;

    initial
    begin
        for (int v = 0; v < DEF_VOICES; v++)
            voice_pos[v] = IDLE_POSITION;
        for (int v = 0; v < LENGTH_REGS; v++)
            voice_len[v] = '0;
        play_enabled = 1'b1;
    end

    // Mirror of one accepted word: loads fill memory, triggers rewind a
    // voice (only while enabled), ticks mix every voice still below its
    // length and advance it.
    function automatic void mix_word_accepted(logic [CMD_W-1:0] cmd, logic [VOICE_W-1:0] voice,
                                              logic [ADDR_FIELD_W-1:0] addr,
                                              logic [SAMPLE_W-1:0] word);
        int                   sum;
        int                   idx;
        logic signed [15:0]   rd;
        mix_word_t            res;
        sum = 0;
        if (cmd == CMD_LOAD)
        begin
            idx = int'(voice) * DEF_VOICE_DEPTH + int'(addr);
            voice_mem[idx]  = word;
            mem_loaded[idx] = 1'b1;
        end
        else if (cmd == CMD_TRIGGER)
        begin
            if (play_enabled)
                voice_pos[voice] = '0;
        end
        else if (cmd == CMD_TICK)
        begin
            for (int v = 0; v < DEF_VOICES; v++)
            begin
                if (voice_pos[v] < voice_len[v])
                begin
                    // Positions beyond the memory depth wrap around it.
                    idx = v * DEF_VOICE_DEPTH + int'(voice_pos[v]) % DEF_VOICE_DEPTH;
                    rd  = voice_mem[idx];
                    sum = sum + rd;
                    voice_pos[v] = voice_pos[v] + 1'b1;
                end
            end
            res.clipped = 1'b0;
            if (sum > SAT_HIGH)
            begin
                sum = SAT_HIGH;
                res.clipped = 1'b1;
            end
            else if (sum < SAT_LOW)
            begin
                sum = SAT_LOW;
                res.clipped = 1'b1;
            end
            res.mixed = sum[15:0];
            pending_mixes.push_back(res);
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Sample values: the two extremes, zero and minus one often, otherwise anything.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side. Fields change at the falling edge; acceptance is seen at
    // the rising edge. tvalid stays high from one word to the next when
    // there is no gap, so it is never dropped and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [VOICE_W-1:0] voice,
                             logic [ADDR_FIELD_W-1:0] addr, logic [SAMPLE_W-1:0] word);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        // s_tdata from bit 0 up: voice, address, sample word.
        s_tdata  <= {word, addr, voice};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        mix_word_accepted(cmd, voice, addr, word);
    endtask

    // A tick is preceded by loads for every sample that it would read and
    // that was never written. The other fields of a tick carry random bits.
    task automatic send_tick();
        int idx;
        for (int v = 0; v < DEF_VOICES; v++)
        begin
            idx = v * DEF_VOICE_DEPTH + int'(voice_pos[v]) % DEF_VOICE_DEPTH;
            if (voice_pos[v] < voice_len[v] && !mem_loaded[idx])
                send_word(CMD_LOAD, v[1:0], voice_pos[v][13:0], pick_sample());
        end
        send_word(CMD_TICK, 2'($urandom_range(0, 3)), 14'($urandom_range(0, 16383)),
                  16'($urandom_range(0, 16'hFFFF)));
    endtask

    // Stop sending and wait for every predicted mixed word to come out.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_mixes.size() != 0)
            @(posedge clk);
    endtask

    // Drained, then a further wait for loads and triggers still in flight;
    // after this the register file may be written.
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_ENABLE)
            play_enabled = value[0];
        else
            voice_len[int'(idx) - int'(REG_LEN0)] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: the receiver stalls at random unless it is in a steady
    // stretch, and every accepted word is checked against the oldest
    // prediction.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!rx_steady)
                rx_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_mixes.size() == 0)
            begin
                $error("mixed word with no tick waiting: mixed_sample %0d, clipped %0d",
                       $signed(m_tdata), m_tuser[0]);
                mismatch_count++;
            end
            else
            begin
                want = pending_mixes.pop_front();
                if (m_tdata !== want.mixed)
                begin
                    $error("mixed_sample: expected %0d, got %0d",
                           $signed(want.mixed), $signed(m_tdata));
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.clipped)
                begin
                    $error("clipped: expected %0d, got %0d", want.clipped, m_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_sample_voice_mixer_core: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Straight after reset every length is zero, so ticks are silent. The
    // unused command must not produce a word. Voice 3 is left idle on
    // purpose for the next test.
    task automatic test_reset_silence();
        send_tick();
        send_tick();
        send_word(CMD_UNUSED, 2'd3, 14'h3FFF, 16'hFFFF);
        send_word(CMD_TRIGGER, 2'd0, 14'h0000, 16'h0000);
        send_tick();
        settle();
    endtask

    // An idle voice sits at the idle position; with its length set above
    // that, it plays on from there and the read address wraps to zero.
    // Also covers the top address and a single voice hitting both rails
    // exactly without clipping.
    task automatic test_length_beyond_idle();
        write_reg(REG_LEN3, 15'd16387);
        send_word(CMD_LOAD, 2'd3, 14'd0, 16'h7FFF);
        send_word(CMD_LOAD, 2'd3, 14'd1, 16'h8000);
        send_word(CMD_LOAD, 2'd3, 14'd2, 16'h0001);
        send_word(CMD_LOAD, 2'd3, 14'h3FFF, 16'h5555);
        repeat (4) send_tick();
        settle();
    endtask

    // Three voices at full scale overflow both ways.
    task automatic test_saturation();
        for (int v = 0; v < 3; v++)
            write_reg(cfg_reg_t'(int'(REG_LEN0) + v), 15'd2);
        for (int v = 0; v < 3; v++)
        begin
            send_word(CMD_LOAD, v[1:0], 14'd0, 16'h7FFF);
            send_word(CMD_LOAD, v[1:0], 14'd1, 16'h8000);
        end
        for (int v = 0; v < 3; v++)
            send_word(CMD_TRIGGER, v[1:0], 14'h2AAA, 16'hAAAA);
        repeat (3) send_tick();
        settle();
    endtask

    // With playback disabled a trigger is dropped; re-enabled it works again.
    task automatic test_trigger_disabled();
        write_reg(REG_ENABLE, 15'd0);
        send_word(CMD_TRIGGER, 2'd0, 14'd0, 16'd0);
        send_tick();
        settle();
        write_reg(REG_ENABLE, 15'd1);
        send_word(CMD_TRIGGER, 2'd1, 14'h1555, 16'h5555);
        send_tick();
        settle();
    endtask

    // The sender holds off until every mixed word has come back, then goes on.
    task automatic test_drain_pause();
        send_word(CMD_TRIGGER, 2'd2, 14'd0, 16'd0);
        send_tick();
        wait_drained();
        send_tick();
        send_tick();
        settle();
    endtask

    // One random word. Loads mostly hit the low addresses that the voices
    // actually play; useful tells whether the block does anything with it.
    task automatic random_word(output bit useful);
        int r;
        r = $urandom_range(0, 99);
        useful = 1'b1;
        if (r < 30)
            send_word(CMD_LOAD, 2'($urandom_range(0, 3)),
                      ($urandom_range(0, 9) < 7) ? 14'($urandom_range(0, 63))
                                                 : 14'($urandom_range(0, 16383)),
                      pick_sample());
        else if (r < 45)
        begin
            useful = play_enabled;
            send_word(CMD_TRIGGER, 2'($urandom_range(0, 3)), 14'($urandom_range(0, 16383)),
                      16'($urandom_range(0, 16'hFFFF)));
        end
        else if (r < 95)
            send_tick();
        else
        begin
            useful = 1'b0;
            send_word(CMD_UNUSED, 2'($urandom_range(0, 3)), 14'($urandom_range(0, 16383)),
                      16'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 15'd0;
        if (r < 20)
            return 15'd16384;
        if (r < 25)
            return 15'($urandom_range(16385, 16400));
        return 15'($urandom_range(1, 48));
    endfunction

    // Several register settings, extremes among them, each followed by a
    // stretch of random traffic.
    task automatic test_random_phases();
        int  done;
        bit  useful;
        logic [CFG_DATA_W-1:0] lens [0:LENGTH_REGS-1];
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            for (int v = 0; v < LENGTH_REGS; v++)
                lens[v] = pick_length();
            if (p == 2)
            begin
                // Longest lengths; one voice even at the top of the register.
                lens[0] = 15'd16384;
                lens[1] = 15'd16384;
                lens[2] = 15'd16384;
                lens[3] = 15'h7FFF;
            end
            else if (p == 3)
            begin
                lens[0] = 15'd0;
                lens[1] = 15'd1;
                lens[2] = 15'd0;
                lens[3] = 15'd1;
            end
            write_reg(REG_ENABLE,
                      (p == 1) ? 15'd0 : (p == 4) ? 15'($urandom_range(0, 1)) : 15'd1);
            for (int v = 0; v < LENGTH_REGS; v++)
                write_reg(cfg_reg_t'(int'(REG_LEN0) + v), lens[v]);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            done = 0;
            while (done < PHASE_WORDS)
            begin
                random_word(useful);
                if (useful)
                    done++;
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_silence();
        test_length_beyond_idle();
        test_saturation();
        test_trigger_disabled();
        test_drain_pause();
        test_random_phases();
        settle();

        if (mismatch_count == 0)
            $display("tb_sample_voice_mixer_core: clean");
        else
            $display("tb_sample_voice_mixer_core: errors");
        $finish;
    end

endmodule

`default_nettype wire
